// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/tmps_pkg.sv =====
// Shared constants and codes for the three move position sequencer.
// Used by the sequencer core; depends on nothing.
package tmps_pkg;

	localparam int POSITION_BITS = 32;
	localparam int TIMER_BITS    = 16;
	// Width at which timers and their 16-bit limits are compared.
	localparam int TCMP_BITS     = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int APB_ADDR_BITS = 5;

	// Input operations.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;
	localparam logic [1:0] OP_REPORT = 2'd3;

	// Command kinds.
	localparam logic [1:0] CMD_MOVE  = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Sequence phases.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_MOVE1 = 3'd1;
	localparam logic [2:0] PH_BACK  = 3'd2;
	localparam logic [2:0] PH_MOVE2 = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	// Move directions.
	localparam logic DIR_FWD  = 1'b0;
	localparam logic DIR_BACK = 1'b1;

	// Register indexes (byte address / 4).
	localparam logic [2:0] REG_ADDRESS   = 3'd0;
	localparam logic [2:0] REG_FIRST     = 3'd1;
	localparam logic [2:0] REG_SECOND    = 3'd2;
	localparam logic [2:0] REG_THIRD     = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;
	localparam logic [2:0] REG_INTERVAL  = 3'd5;
	localparam logic [2:0] REG_TIMEOUT   = 3'd6;
	localparam logic [2:0] REG_SPEED     = 3'd7;

	// Register reset values.
	localparam logic [7:0]  RST_ADDRESS   = 8'h01;
	localparam logic [19:0] RST_FIRST     = 20'd819;
	localparam logic [19:0] RST_SECOND    = 20'd1635;
	localparam logic [19:0] RST_THIRD     = 20'd2451;
	localparam logic [15:0] RST_TOLERANCE = 16'd10;
	localparam logic [15:0] RST_INTERVAL  = 16'd50;
	localparam logic [15:0] RST_TIMEOUT   = 16'd5000;
	localparam logic [11:0] RST_SPEED     = 12'd300;

endpackage

// ===== sv/tmps_if.sv =====
// Valid/ready channel interfaces for the sequencer's request and command streams.
// Depends on nothing; field widths are fixed by the item formats.
interface tmps_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] reported_position;

	modport source(output valid, operation, reported_position, input ready);
	modport sink(input valid, operation, reported_position, output ready);
endinterface

interface tmps_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command_kind;
	logic [7:0]         address_out;
	logic               move_direction;
	logic [19:0]        move_pulses;
	logic [11:0]        speed_out;
	logic [2:0]         phase_after;
	logic signed [31:0] target_after;

	modport source(output valid, command_kind, address_out, move_direction, move_pulses,
		speed_out, phase_after, target_after, input ready);
	modport sink(input valid, command_kind, address_out, move_direction, move_pulses,
		speed_out, phase_after, target_after, output ready);
endinterface

// ===== sv/three_move_position_sequencer_core.sv =====
// Three move position sequencer: forward, backward, forward on one stepper axis.
// A transaction accepted into the input stage loads its command into the result register when it advances.
// Throughput: one transaction per cycle; input stalls only while the result register
// holds a command that has not been taken and the staged transaction would produce another.
// Reset (arst_n low, asynchronous) sets registers to defaults, phase idle, target zero.
// Depends on tmps_pkg, tmps_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module three_move_position_sequencer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	tmps_item_if.sink                          items,
	tmps_result_if.source                      results,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tmps_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int PB = tmps_pkg::POSITION_BITS;
	localparam int TB = tmps_pkg::TIMER_BITS;
	localparam int CB = tmps_pkg::TCMP_BITS;

	// Configuration registers.
	logic [7:0]  motor_address_q;
	logic [19:0] first_pulses_q;
	logic [19:0] second_pulses_q;
	logic [19:0] third_pulses_q;
	logic [15:0] tolerance_q;
	logic [15:0] interval_q;
	logic [15:0] timeout_q;
	logic [11:0] speed_q;

	logic [2:0] reg_index;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_address_q <= tmps_pkg::RST_ADDRESS;
			first_pulses_q  <= tmps_pkg::RST_FIRST;
			second_pulses_q <= tmps_pkg::RST_SECOND;
			third_pulses_q  <= tmps_pkg::RST_THIRD;
			tolerance_q     <= tmps_pkg::RST_TOLERANCE;
			interval_q      <= tmps_pkg::RST_INTERVAL;
			timeout_q       <= tmps_pkg::RST_TIMEOUT;
			speed_q         <= tmps_pkg::RST_SPEED;
		end else if (cfg_write) begin
			case (reg_index)
				tmps_pkg::REG_ADDRESS:   motor_address_q <= pwdata[7:0];
				tmps_pkg::REG_FIRST:     first_pulses_q  <= pwdata[19:0];
				tmps_pkg::REG_SECOND:    second_pulses_q <= pwdata[19:0];
				tmps_pkg::REG_THIRD:     third_pulses_q  <= pwdata[19:0];
				tmps_pkg::REG_TOLERANCE: tolerance_q     <= pwdata[15:0];
				tmps_pkg::REG_INTERVAL:  interval_q      <= pwdata[15:0];
				tmps_pkg::REG_TIMEOUT:   timeout_q       <= pwdata[15:0];
				tmps_pkg::REG_SPEED:     speed_q         <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			tmps_pkg::REG_ADDRESS:   prdata = {24'd0, motor_address_q};
			tmps_pkg::REG_FIRST:     prdata = {12'd0, first_pulses_q};
			tmps_pkg::REG_SECOND:    prdata = {12'd0, second_pulses_q};
			tmps_pkg::REG_THIRD:     prdata = {12'd0, third_pulses_q};
			tmps_pkg::REG_TOLERANCE: prdata = {16'd0, tolerance_q};
			tmps_pkg::REG_INTERVAL:  prdata = {16'd0, interval_q};
			tmps_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_q};
			tmps_pkg::REG_SPEED:     prdata = {20'd0, speed_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Input stage.
	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic signed [PB-1:0] pos_s1;
	logic                 advance;

	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_s1  <= items.operation;
			pos_s1 <= PB'(items.reported_position);
		end
	end

	// Sequencer state.
	logic [2:0]           phase_q;
	logic                 running_q;
	logic [TB-1:0]        step_ticks_q;
	logic [TB-1:0]        since_query_q;
	logic                 awaiting_q;
	logic signed [PB-1:0] target_q;

	logic [2:0]           phase_d;
	logic                 running_d;
	logic [TB-1:0]        step_ticks_d;
	logic [TB-1:0]        since_query_d;
	logic                 awaiting_d;
	logic signed [PB-1:0] target_d;

	logic [TB-1:0]        step_inc;
	logic [TB-1:0]        query_inc;
	logic signed [PB-1:0] error_pos;
	logic [PB-1:0]        error_mag;
	logic                 arrived;
	logic                 move_dir;
	logic [19:0]          move_len;
	logic signed [PB-1:0] move_target;

	logic        has_result;
	logic [1:0]  res_kind;
	logic        res_move;

	assign step_inc  = (step_ticks_q == {TB{1'b1}}) ? step_ticks_q : step_ticks_q + 1'b1;
	assign query_inc = (since_query_q == {TB{1'b1}}) ? since_query_q : since_query_q + 1'b1;

	// The arrival check always uses the position of the report at hand, so no stored
	// copy of the last position is needed.
	assign error_pos = target_q - pos_s1;
	assign error_mag = error_pos[PB-1] ? PB'(-error_pos) : PB'(error_pos);
	assign arrived   = error_mag <= PB'(tolerance_q);

	// The next move follows from the current phase, the one about to be left.
	always_comb begin
		case (phase_q)
			tmps_pkg::PH_MOVE1: begin
				move_dir = tmps_pkg::DIR_BACK;
				move_len = second_pulses_q;
			end
			tmps_pkg::PH_BACK: begin
				move_dir = tmps_pkg::DIR_FWD;
				move_len = third_pulses_q;
			end
			default: begin
				move_dir = tmps_pkg::DIR_FWD;
				move_len = first_pulses_q;
			end
		endcase
	end

	assign move_target = (move_dir == tmps_pkg::DIR_BACK) ?
		target_q - PB'(move_len) : target_q + PB'(move_len);

	always_comb begin
		phase_d        = phase_q;
		running_d      = running_q;
		step_ticks_d   = step_ticks_q;
		since_query_d  = since_query_q;
		awaiting_d     = awaiting_q;
		target_d       = target_q;
		has_result     = 1'b0;
		res_kind       = tmps_pkg::CMD_STOP;
		res_move       = 1'b0;
		case (op_s1)
			tmps_pkg::OP_TICK: begin
				since_query_d = query_inc;
				if (running_q) begin
					step_ticks_d = step_inc;
					if (CB'(step_inc) > CB'(timeout_q)) begin
						phase_d    = tmps_pkg::PH_IDLE;
						running_d  = 1'b0;
						has_result = 1'b1;
						res_kind   = tmps_pkg::CMD_STOP;
					end else if (!awaiting_q && CB'(query_inc) >= CB'(interval_q)) begin
						since_query_d = '0;
						awaiting_d    = 1'b1;
						has_result    = 1'b1;
						res_kind      = tmps_pkg::CMD_QUERY;
					end
				end
			end
			tmps_pkg::OP_START: begin
				if (!running_q) begin
					phase_d = tmps_pkg::PH_MOVE1;
					running_d = 1'b1;
					has_result = 1'b1;
					res_kind = tmps_pkg::CMD_MOVE;
					res_move = 1'b1;
				end
			end
			tmps_pkg::OP_STOP: begin
				if (running_q) begin
					phase_d    = tmps_pkg::PH_IDLE;
					running_d  = 1'b0;
					has_result = 1'b1;
					res_kind   = tmps_pkg::CMD_STOP;
				end
			end
			default: begin
				if (running_q) begin
					awaiting_d = 1'b0;
					if (arrived) begin
						case (phase_q)
							tmps_pkg::PH_MOVE1: begin
								phase_d    = tmps_pkg::PH_BACK;
								has_result = 1'b1;
								res_kind   = tmps_pkg::CMD_MOVE;
								res_move   = 1'b1;
							end
							tmps_pkg::PH_BACK: begin
								phase_d    = tmps_pkg::PH_MOVE2;
								has_result = 1'b1;
								res_kind   = tmps_pkg::CMD_MOVE;
								res_move   = 1'b1;
							end
							tmps_pkg::PH_MOVE2: begin
								phase_d    = tmps_pkg::PH_DONE;
								running_d  = 1'b0;
								has_result = 1'b1;
								res_kind   = tmps_pkg::CMD_STOP;
							end
							default: begin
								phase_d   = tmps_pkg::PH_IDLE;
								running_d = 1'b0;
							end
						endcase
					end
				end
			end
		endcase
		if (res_move) begin
			target_d       = move_target;
			step_ticks_d   = '0;
			awaiting_d     = 1'b0;
		end
	end

	// A staged transaction moves on unless its command would overwrite a waiting one.
	assign advance = valid_s1 && (!has_result || !results.valid || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= tmps_pkg::PH_IDLE;
			running_q      <= 1'b0;
			step_ticks_q   <= '0;
			since_query_q  <= '1;
			awaiting_q     <= 1'b0;
			target_q       <= '0;
		end else if (advance) begin
			phase_q        <= phase_d;
			running_q      <= running_d;
			step_ticks_q   <= step_ticks_d;
			since_query_q  <= since_query_d;
			awaiting_q     <= awaiting_d;
			target_q       <= target_d;
		end
	end

	// Result register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			results.command_kind   <= res_kind;
			results.address_out    <= motor_address_q;
			results.move_direction <= res_move ? move_dir : 1'b0;
			results.move_pulses    <= res_move ? move_len : 20'd0;
			results.speed_out      <= res_move ? speed_q : 12'd0;
			results.phase_after    <= phase_d;
			results.target_after   <= 32'(target_d);
		end
	end

	assign results.valid = out_valid_q;

	`ASSERT_SAME(a_idle_phase, !running_q,
		phase_q == tmps_pkg::PH_IDLE || phase_q == tmps_pkg::PH_DONE)
	`ASSERT_SAME(a_run_phase, running_q,
		phase_q == tmps_pkg::PH_MOVE1 || phase_q == tmps_pkg::PH_BACK ||
		phase_q == tmps_pkg::PH_MOVE2)
	`ASSERT_SAME(a_plain_command, out_valid_q && results.command_kind != tmps_pkg::CMD_MOVE,
		results.move_pulses == 20'd0 && results.speed_out == 12'd0)
	`ASSERT_NEXT(a_start_moves, advance && op_s1 == tmps_pkg::OP_START && !running_q,
		out_valid_q && results.command_kind == tmps_pkg::CMD_MOVE && running_q)

endmodule
